// ----- sv/keymap_modifier_lookup_table_macros.svh -----
// Assertion macros shared by the keymap lookup table checker.
`ifndef KEYMAP_MODIFIER_LOOKUP_TABLE_MACROS_SVH
`define KEYMAP_MODIFIER_LOOKUP_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KML_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keymap lookup table check failed");

// The consequent must hold in the cycle after the antecedent.
`define KML_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keymap lookup table check failed");

`endif

// ----- sv/kml_pkg.sv -----
// Types and constants shared by the keymap lookup table modules.
`default_nettype none

package kml_pkg;

    localparam int KIND_W   = 3;
    localparam int CODE_W   = 10;
    localparam int META_W   = 23;
    localparam int CHR_W    = 16;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 120;

    // Operation kinds carried in s_tuser.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEFINE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd4;

    // Result status codes carried in m_tuser.
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_KEY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] key_code;
        logic [META_W-1:0] meta_state;
        logic [CHR_W-1:0]  char_value;
        logic [CHR_W-1:0]  label_value;
        logic [CHR_W-1:0]  number_value;
        logic [CODE_W-1:0] fallback_code;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHR_W-1:0]    label_out;
        logic [CHR_W-1:0]    number_out;
        logic [CHR_W-1:0]    char_out;
        logic [CODE_W-1:0]   fallback_out;
        logic [META_W-1:0]   fallback_meta_out;
        logic [CODE_W-1:0]   found_code;
        logic [META_W-1:0]   found_meta;
    } res_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CHR_W-1:0]  label;
        logic [CHR_W-1:0]  number;
    } key_row_t;

    typedef struct packed {
        logic [CODE_W-1:0] owner;
        logic [META_W-1:0] mask;
        logic [CHR_W-1:0]  chr;
        logic [CODE_W-1:0] fallback;
    } entry_row_t;

endpackage

`default_nettype wire

// ----- sv/kml_ram.sv -----
// Single-port-write, single-port-read synchronous memory with registered read data.
`default_nettype none

module kml_ram #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/kml_ctrl.sv -----
// Sequencer that scans the key and behaviour memories and builds one result per beat.
`default_nettype none

module kml_ctrl #(
    parameter int  MAX_KEYS    = 64,
    parameter int  MAX_ENTRIES = 256,
    localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int KCW = $clog2(MAX_KEYS + 1),
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int ECW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire kml_pkg::req_t         in_req,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output kml_pkg::res_t              res,
    output logic                       key_we,
    output logic [KW-1:0]              key_waddr,
    output kml_pkg::key_row_t          key_wdata,
    output logic [KW-1:0]              key_raddr,
    input  wire kml_pkg::key_row_t     key_rdata,
    output logic                       entry_we,
    output logic [EW-1:0]              entry_waddr,
    output kml_pkg::entry_row_t        entry_wdata,
    output logic [EW-1:0]              entry_raddr,
    input  wire kml_pkg::entry_row_t   entry_rdata
);

    import kml_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_KSCAN, S_ESCAN, S_FINISH} state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    res_t                res_reg, res_next;
    logic [MAX_KEYS-1:0] key_used_reg, key_used_next;
    logic [ECW-1:0]      entry_total_reg, entry_total_next;
    logic [KCW-1:0]      kidx_reg, kidx_next;
    logic                kcmp_valid_reg, kcmp_valid_next;
    logic [KW-1:0]       kcmp_idx_reg, kcmp_idx_next;
    logic                free_found_reg, free_found_next;
    logic [KW-1:0]       free_idx_reg, free_idx_next;
    logic [EW-1:0]       eaddr_reg, eaddr_next;
    logic [ECW-1:0]      eleft_reg, eleft_next;
    logic                ecmp_valid_reg, ecmp_valid_next;
    logic                ecmp_last_reg, ecmp_last_next;
    logic                best_hit_reg, best_hit_next;
    logic [CODE_W-1:0]   best_code_reg, best_code_next;
    logic [META_W-1:0]   best_mask_reg, best_mask_next;

    logic                issue_k, issue_e;
    logic                k_hit, k_last, e_own, e_dup, e_match, c_hit;
    logic                add_try;
    logic [ECW-1:0]      total_less1;

    assign key_raddr   = kidx_reg[KW-1:0];
    assign entry_raddr = eaddr_reg;
    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_FINISH);
    assign res         = res_reg;

    assign issue_k = (state_reg == S_KSCAN) && (kidx_reg < KCW'(MAX_KEYS));
    assign issue_e = (state_reg == S_ESCAN) && (eleft_reg != '0);

    assign k_hit  = kcmp_valid_reg && key_used_reg[kcmp_idx_reg]
                    && (key_rdata.code == req_reg.key_code);
    assign k_last = kcmp_valid_reg && (kcmp_idx_reg == KW'(MAX_KEYS - 1));

    assign e_own   = (entry_rdata.owner == req_reg.key_code);
    assign e_dup   = e_own && (entry_rdata.mask == req_reg.meta_state);
    assign e_match = e_own && ((entry_rdata.mask & req_reg.meta_state) == entry_rdata.mask);
    assign c_hit   = (entry_rdata.chr == req_reg.char_value)
                     && (!best_hit_reg || (entry_rdata.owner < best_code_reg));

    assign total_less1 = entry_total_reg - ECW'(1);

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        res_next         = res_reg;
        key_used_next    = key_used_reg;
        entry_total_next = entry_total_reg;
        kidx_next        = kidx_reg;
        kcmp_valid_next  = 1'b0;
        kcmp_idx_next    = kcmp_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        eaddr_next       = eaddr_reg;
        eleft_next       = eleft_reg;
        ecmp_valid_next  = 1'b0;
        ecmp_last_next   = ecmp_last_reg;
        best_hit_next    = best_hit_reg;
        best_code_next   = best_code_reg;
        best_mask_next   = best_mask_reg;
        add_try          = 1'b0;

        key_we             = 1'b0;
        key_waddr          = free_idx_reg;
        key_wdata.code     = req_reg.key_code;
        key_wdata.label    = req_reg.label_value;
        key_wdata.number   = req_reg.number_value;
        entry_we           = 1'b0;
        entry_waddr        = entry_total_reg[EW-1:0];
        entry_wdata.owner    = req_reg.key_code;
        entry_wdata.mask     = req_reg.meta_state;
        entry_wdata.chr      = req_reg.char_value;
        entry_wdata.fallback = req_reg.fallback_code;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next        = in_req;
                    res_next        = '0;
                    kidx_next       = '0;
                    free_found_next = 1'b0;
                    best_hit_next   = 1'b0;
                    case (in_req.kind)
                        KIND_CLEAR: begin
                            key_used_next    = '0;
                            entry_total_next = '0;
                            res_next.status  = ST_DONE;
                            state_next       = S_FINISH;
                        end
                        KIND_DEFINE, KIND_ADD: begin
                            if (in_req.key_code == '0) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_FINISH;
                            end else begin
                                state_next = S_KSCAN;
                            end
                        end
                        KIND_LOOKUP: begin
                            state_next = S_KSCAN;
                        end
                        KIND_FIND: begin
                            if (in_req.char_value == '0) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_FINISH;
                            end else if (entry_total_reg == '0) begin
                                res_next.status = ST_NO_KEY;
                                state_next      = S_FINISH;
                            end else begin
                                eaddr_next = '0;
                                eleft_next = entry_total_reg;
                                state_next = S_ESCAN;
                            end
                        end
                        default: begin
                            res_next.status = ST_INVALID;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end

            S_KSCAN: begin
                if (issue_k) begin
                    kidx_next       = kidx_reg + KCW'(1);
                    kcmp_valid_next = 1'b1;
                    kcmp_idx_next   = kidx_reg[KW-1:0];
                end
                if (kcmp_valid_reg && !key_used_reg[kcmp_idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = kcmp_idx_reg;
                end
                if (k_hit) begin
                    case (req_reg.kind)
                        KIND_DEFINE: begin
                            res_next.status = ST_DUP;
                            state_next      = S_FINISH;
                        end
                        KIND_ADD: begin
                            if (entry_total_reg == '0) begin
                                add_try = 1'b1;
                            end else begin
                                eaddr_next = '0;
                                eleft_next = entry_total_reg;
                                state_next = S_ESCAN;
                            end
                        end
                        default: begin
                            res_next.label_out  = key_rdata.label;
                            res_next.number_out = key_rdata.number;
                            res_next.status     = ST_NO_MATCH;
                            if (entry_total_reg == '0) begin
                                state_next = S_FINISH;
                            end else begin
                                eaddr_next = total_less1[EW-1:0];
                                eleft_next = entry_total_reg;
                                state_next = S_ESCAN;
                            end
                        end
                    endcase
                end else if (k_last) begin
                    state_next = S_FINISH;
                    if (req_reg.kind == KIND_DEFINE) begin
                        if (free_found_reg || !key_used_reg[kcmp_idx_reg]) begin
                            key_we    = 1'b1;
                            key_waddr = free_found_reg ? free_idx_reg : kcmp_idx_reg;
                            key_used_next[key_waddr] = 1'b1;
                            res_next.status = ST_DONE;
                        end else begin
                            res_next.status = ST_FULL;
                        end
                    end else begin
                        res_next.status = ST_NO_KEY;
                    end
                end
            end

            S_ESCAN: begin
                if (issue_e) begin
                    eleft_next      = eleft_reg - ECW'(1);
                    eaddr_next      = (req_reg.kind == KIND_LOOKUP) ? eaddr_reg - EW'(1)
                                                                    : eaddr_reg + EW'(1);
                    ecmp_valid_next = 1'b1;
                    ecmp_last_next  = (eleft_reg == ECW'(1));
                end
                if (ecmp_valid_reg) begin
                    case (req_reg.kind)
                        KIND_ADD: begin
                            if (e_dup) begin
                                res_next.status = ST_DUP;
                                state_next      = S_FINISH;
                            end else if (ecmp_last_reg) begin
                                add_try = 1'b1;
                            end
                        end
                        KIND_LOOKUP: begin
                            if (e_match) begin
                                res_next.status   = ST_DONE;
                                res_next.char_out = entry_rdata.chr;
                                if (entry_rdata.fallback != '0) begin
                                    res_next.fallback_out      = entry_rdata.fallback;
                                    res_next.fallback_meta_out =
                                        req_reg.meta_state & ~entry_rdata.mask;
                                end
                                state_next = S_FINISH;
                            end else if (ecmp_last_reg) begin
                                state_next = S_FINISH;
                            end
                        end
                        default: begin
                            if (c_hit) begin
                                best_hit_next  = 1'b1;
                                best_code_next = entry_rdata.owner;
                                best_mask_next = entry_rdata.mask;
                            end
                            if (ecmp_last_reg) begin
                                state_next = S_FINISH;
                                if (best_hit_next) begin
                                    res_next.status     = ST_DONE;
                                    res_next.found_code = best_code_next;
                                    res_next.found_meta = best_mask_next;
                                end else begin
                                    res_next.status = ST_NO_KEY;
                                end
                            end
                        end
                    endcase
                end
            end

            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Appending a behaviour, or reporting a full table, once the key exists and no duplicate mask was seen.
        if (add_try) begin
            state_next = S_FINISH;
            if (entry_total_reg == ECW'(MAX_ENTRIES)) begin
                res_next.status = ST_FULL;
            end else begin
                entry_we         = 1'b1;
                entry_total_next = entry_total_reg + ECW'(1);
                res_next.status  = ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        kidx_reg      <= kidx_next;
        kcmp_idx_reg  <= kcmp_idx_next;
        free_idx_reg  <= free_idx_next;
        eaddr_reg     <= eaddr_next;
        eleft_reg     <= eleft_next;
        ecmp_last_reg <= ecmp_last_next;
        best_code_reg <= best_code_next;
        best_mask_reg <= best_mask_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            key_used_reg    <= '0;
            entry_total_reg <= '0;
            kcmp_valid_reg  <= 1'b0;
            ecmp_valid_reg  <= 1'b0;
            free_found_reg  <= 1'b0;
            best_hit_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            key_used_reg    <= key_used_next;
            entry_total_reg <= entry_total_next;
            kcmp_valid_reg  <= kcmp_valid_next;
            ecmp_valid_reg  <= ecmp_valid_next;
            free_found_reg  <= free_found_next;
            best_hit_reg    <= best_hit_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/keymap_modifier_lookup_table.sv -----
// Top level of the keymap modifier lookup table: stream ports, memories and result register.
//
// Each beat on the s_ channel carries one command, selected by s_tuser: clear, define a key,
// add a behaviour, look a key up under a modifier state, or find the key that types a
// character. Exactly one result beat leaves on the m_ channel for every command, with the
// status code in m_tuser and the looked-up or found values in m_tdata.
// Keys live in a memory of MAX_KEYS rows and behaviours in a memory of MAX_ENTRIES rows,
// both with registered read data. A define, add or lookup first walks the key memory,
// one row a cycle, until the key is found or the last row is read; an add, lookup or
// reverse find then walks the stored behaviours, one a cycle. A clear, or a command
// refused on its fields alone, skips these walks. The memory walks set the rate, and one
// command is in progress at a time.
// Reset (aresetn low at a clock edge) empties both tables at once; no clearing pass is run.
// The result sits in an output register, so the next command is taken while a result waits.
// If the receiver holds m_tready low, a second finished result waits inside the sequencer
// and no further command is taken until the first has been delivered.
`default_nettype none

module keymap_modifier_lookup_table #(
    parameter int MAX_KEYS    = 64,
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // key_code, meta_state, char_value, label_value, number_value, fallback_code
    input  wire logic [kml_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  wire logic [kml_pkg::KIND_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // label_out, number_out, char_out, fallback_out, fallback_meta_out, found_code, found_meta
    output logic [kml_pkg::M_TDATA_W-1:0]         m_tdata,
    // status
    output logic [kml_pkg::STATUS_W-1:0]          m_tuser
);

    import kml_pkg::*;

    localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    req_t       in_req;
    res_t       res;
    logic       res_valid, res_ready;
    logic       key_we, entry_we;
    logic [KW-1:0] key_waddr, key_raddr;
    logic [EW-1:0] entry_waddr, entry_raddr;
    key_row_t   key_wdata, key_rdata;
    entry_row_t entry_wdata, entry_rdata;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    // Unpack the command beat, lowest field first.
    assign in_req.kind          = s_tuser;
    assign in_req.key_code      = s_tdata[9:0];
    assign in_req.meta_state    = s_tdata[32:10];
    assign in_req.char_value    = s_tdata[48:33];
    assign in_req.label_value   = s_tdata[64:49];
    assign in_req.number_value  = s_tdata[80:65];
    assign in_req.fallback_code = s_tdata[90:81];

    kml_ctrl #(
        .MAX_KEYS    (MAX_KEYS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (in_req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .key_we      (key_we),
        .key_waddr   (key_waddr),
        .key_wdata   (key_wdata),
        .key_raddr   (key_raddr),
        .key_rdata   (key_rdata),
        .entry_we    (entry_we),
        .entry_waddr (entry_waddr),
        .entry_wdata (entry_wdata),
        .entry_raddr (entry_raddr),
        .entry_rdata (entry_rdata)
    );

    // Key rows: code, label and number character of each defined key.
    kml_ram #(
        .DEPTH (MAX_KEYS),
        .WIDTH ($bits(key_row_t))
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Behaviour rows in the order they were added.
    kml_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH ($bits(entry_row_t))
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (entry_we),
        .waddr (entry_waddr),
        .wdata (entry_wdata),
        .raddr (entry_raddr),
        .rdata (entry_rdata)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tuser_reg <= res.status;
            m_tdata_reg <= {6'd0, res.found_meta, res.found_code, res.fallback_meta_out,
                            res.fallback_out, res.char_out, res.number_out, res.label_out};
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- sv/kml_checker.sv -----
// Port-level checker for the keymap lookup table, bound to the top level.
`default_nettype none
`include "keymap_modifier_lookup_table_macros.svh"

module kml_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [kml_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire logic [kml_pkg::KIND_W-1:0]      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [kml_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [kml_pkg::STATUS_W-1:0]    m_tuser
);

    import kml_pkg::*;

    localparam int CHAR_LSB  = 32;
    localparam int FB_LSB    = 48;
    localparam int FBM_LSB   = 58;
    localparam int FBM_MSB   = 80;

    logic s_beat;
    assign s_beat = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // A result held back by the receiver keeps its contents.
    `KML_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Commands are worked one at a time, so no beat is taken right after another.
    `KML_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_beat, !s_tready)

    // Only defined status codes are reported.
    `KML_ASSERT_SAME(a_status_code, aclk, aresetn, m_tvalid, m_tuser <= ST_INVALID)

    // Without success, character, fallback and found fields stay zero.
    `KML_ASSERT_SAME(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_DONE), m_tdata[M_TDATA_W-1:CHAR_LSB] == '0)

    // Fallback modifiers appear only together with a fallback key.
    `KML_ASSERT_SAME(a_fb_meta, aclk, aresetn, m_tvalid && (m_tdata[FBM_LSB-1:FB_LSB] == '0), m_tdata[FBM_MSB:FBM_LSB] == '0)

endmodule

bind keymap_modifier_lookup_table kml_checker u_kml_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
